// ===== src/mh2_pkg.sv =====
`timescale 1ns / 1ps

package mh2_pkg;

    // Mixing constants of the 32-bit hash
    localparam logic [31:0] MIX_M = 32'h5bd1e995;
    localparam int unsigned MIX_R = 24;
    localparam int unsigned FIN_R1 = 13;
    localparam int unsigned FIN_R2 = 15;

    // Configuration
    localparam logic [31:0] SEED_RESET = 32'd97;
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0] REG_HASH_SEED = 1'b0;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // What the back end has to do with one word
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_FULL = 2'd2
    } kind_t;

    // One classified word as it travels through the queue
    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic        first;
        logic        last;
        logic [31:0] len;
    } item_t;

endpackage

// ===== src/mh2_if.sv =====
`timescale 1ns / 1ps

interface mh2_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_word;
    logic [2:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
    logic [31:0] key_length;

    modport source (output valid, key_word, valid_bytes, first_word, last_word, key_length,
                    input ready);
    modport sink (input valid, key_word, valid_bytes, first_word, last_word, key_length,
                  output ready);
endinterface

interface mh2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest;

    modport source (output valid, digest, input ready);
    modport sink (input valid, digest, output ready);
endinterface

// ===== src/mh2_front.sv =====
`timescale 1ns / 1ps

module mh2_front (
    mh2_in_if.sink         in_ch,
    input  logic           q_full,
    output logic           push,
    output mh2_pkg::item_t push_item
);

    logic [31:0] tail_word;

    // Keep only the valid bytes of a short word
    always_comb
    begin
        tail_word = {24'd0, in_ch.key_word[7:0]};
        if (in_ch.valid_bytes >= 3'd2)
        begin
            tail_word[15:8] = in_ch.key_word[15:8];
        end
        if (in_ch.valid_bytes >= 3'd3)
        begin
            tail_word[23:16] = in_ch.key_word[23:16];
        end
    end

    // Classify the word: nothing, tail path or full mix
    always_comb
    begin
        push_item.first = in_ch.first_word;
        push_item.last  = in_ch.last_word;
        push_item.len   = in_ch.key_length;
        if (in_ch.valid_bytes >= 3'd4)
        begin
            push_item.kind = mh2_pkg::KIND_FULL;
            push_item.word = in_ch.key_word;
        end
        else if (in_ch.valid_bytes == 3'd0)
        begin
            push_item.kind = mh2_pkg::KIND_NONE;
            push_item.word = 32'd0;
        end
        else
        begin
            push_item.kind = mh2_pkg::KIND_TAIL;
            push_item.word = tail_word;
        end
    end

    // Accept whenever the queue has room
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

endmodule

// ===== src/mh2_queue.sv =====
`timescale 1ns / 1ps

module mh2_queue #(
    parameter int unsigned DEPTH = mh2_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mh2_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output mh2_pkg::item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mh2_pkg::item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on a push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/mh2_back.sv =====
`timescale 1ns / 1ps

module mh2_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    hash_seed,
    input  logic           q_valid,
    input  mh2_pkg::item_t q_item,
    output logic           pop,
    mh2_out_if.source      out_ch
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_KMUL1 = 6'b000010,
        ST_KMUL2 = 6'b000100,
        ST_HMUL  = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_FOUT  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    h_reg, h_next;
    logic [31:0]    k_reg, k_next;
    mh2_pkg::item_t cur_reg, cur_next;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_hash_reg, out_hash_next;

    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [31:0] fin_hash;
    logic        out_free;

    // Select the operand of the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_KMUL1: mul_a = cur_reg.word;
            ST_KMUL2: mul_a = k_reg ^ (k_reg >> mh2_pkg::MIX_R);
            ST_HMUL:  mul_a = h_reg ^ ((cur_reg.kind == mh2_pkg::KIND_TAIL) ? cur_reg.word
                                                                          : 32'd0);
            ST_FIN:   mul_a = h_reg ^ (h_reg >> mh2_pkg::FIN_R1);
            default:  mul_a = 32'd0;
        endcase
    end

    assign prod     = mul_a * mh2_pkg::MIX_M;
    assign fin_hash = h_reg ^ (h_reg >> mh2_pkg::FIN_R2);
    assign out_free = !out_valid_reg || out_ch.ready;

    // Sequence one word through the multiplier
    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_hash_next  = out_hash_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cur_next = q_item;
                    if (q_item.first)
                    begin
                        h_next = hash_seed ^ q_item.len;
                    end
                    unique case (q_item.kind)
                        mh2_pkg::KIND_FULL: state_next = ST_KMUL1;
                        mh2_pkg::KIND_TAIL: state_next = ST_HMUL;
                        default:            state_next = q_item.last ? ST_FIN : ST_IDLE;
                    endcase
                end
            end
            ST_KMUL1:
            begin
                k_next     = prod;
                state_next = ST_KMUL2;
            end
            ST_KMUL2:
            begin
                k_next     = prod;
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                h_next     = prod ^ ((cur_reg.kind == mh2_pkg::KIND_FULL) ? k_reg : 32'd0);
                state_next = cur_reg.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                h_next     = prod;
                state_next = ST_FOUT;
            end
            ST_FOUT:
            begin
                if (out_free)
                begin
                    h_next         = fin_hash;
                    out_valid_next = 1'b1;
                    out_hash_next  = fin_hash;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        out_hash_reg <= out_hash_next;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.digest = out_hash_reg;

    // Checks on the sequencer
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("back state not one-hot");

    a_kmul_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_KMUL1 |=> state_reg == ST_KMUL2)
        else $error("second key multiply skipped");

    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> state_reg == ST_FOUT)
        else $error("finalisation out of order");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != ST_FOUT && state_reg != ST_KMUL2)
        else $error("pop outside idle");

    a_emit_hash: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOUT && out_free |=> out_valid_reg && out_hash_reg == h_reg)
        else $error("emitted hash differs from running hash");

endmodule

// ===== src/murmur2_hash_stream_core.sv =====
`timescale 1ns / 1ps

// MurmurHash2 (32-bit) stream core. A key arrives as little-endian 32-bit
// words on in_ch; the word marked first_word starts from hash_seed XOR
// key_length, and the word marked last_word finalises the hash and sends it
// on out_ch. The front accepts and classifies each word into a short queue;
// the back runs it through one shared 32x32 multiplier, at most one multiply
// a cycle. Four valid bytes take two key multiplies and a hash multiply, one to
// three only the hash multiply, none no multiply; a last word adds the final
// multiply and waits while the output register is held. Words are accepted
// while the queue has room. hash_seed is at APB byte address 0, reset to 97.
module murmur2_hash_stream_core #(
    parameter int unsigned QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mh2_in_if.sink                      in_ch,
    mh2_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mh2_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0]    hash_seed_reg;
    logic           q_full;
    logic           push;
    mh2_pkg::item_t push_item;
    logic           pop;
    logic           q_valid;
    mh2_pkg::item_t q_item;
    logic           cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == mh2_pkg::REG_HASH_SEED);
    assign prdata = (paddr[2] == mh2_pkg::REG_HASH_SEED) ? hash_seed_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= mh2_pkg::SEED_RESET;
        end
        else if (cfg_wr)
        begin
            hash_seed_reg <= pwdata;
        end
    end

    mh2_front u_front (
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    mh2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    mh2_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .hash_seed (hash_seed_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
